>>> hw/rtl/sha_pkg.sv
`default_nettype none
package sha_pkg;

  localparam int unsigned WordW    = 32;
  localparam int unsigned Rounds   = 64;
  localparam int unsigned BlockLen = 16;

  typedef enum logic [2:0] {
    StIdle,
    StLoad,
    StRound,
    StFinish,
    StPad,
    StEmit
  } state_e;

  localparam logic [WordW-1:0] PadWord = 32'h8000_0000;

  function automatic logic [WordW-1:0] hash_init(input logic [2:0] idx);
    logic [WordW-1:0] v;
    case (idx)
      3'd0: v = 32'h6a09e667;
      3'd1: v = 32'hbb67ae85;
      3'd2: v = 32'h3c6ef372;
      3'd3: v = 32'ha54ff53a;
      3'd4: v = 32'h510e527f;
      3'd5: v = 32'h9b05688c;
      3'd6: v = 32'h1f83d9ab;
      default: v = 32'h5be0cd19;
    endcase
    return v;
  endfunction

  function automatic logic [WordW-1:0] round_k(input logic [5:0] idx);
    logic [WordW-1:0] k [64];
    k = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };
    return k[idx];
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/sha256_message_hasher.sv
`default_nettype none
// Channel   Dir  Word contents
// s_axis    in   tdata: message_word[31:0], byte_count[34:32], pad to 40 bits;
//                tlast: message_end
// m_axis    out  tdata: digest_word[31:0], word_index[34:32], pad to 40 bits;
//                tlast: digest_last
// A word that does not fill a block is written into the block memory.
// A word that fills a block adds a load step, 64 rounds and an add step,
// one round a cycle through the schedule memory.
// A final word adds padding writes (up to 17), one or two compressions and 8
// output words. Reset restores the initial hash value; the output register
// holds a digest word while m_axis_tready is low, and no input is taken then.
module sha256_message_hasher (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,   // message_word, byte_count
  input  wire logic        s_axis_tlast,   // message_end
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,   // digest_word, word_index
  output logic             m_axis_tlast    // digest_last
);
  import sha_pkg::*;

  // Schedule memory: 16-entry sliding window, one write and reads at
  // four addresses per round are served from a shift line of registered words.
  logic [WordW-1:0] w_q [BlockLen];
  logic [WordW-1:0] cv_q [8];
  logic [WordW-1:0] v_q [8];
  state_e           state_q, state_d;
  logic [3:0]       fill_q;
  logic [63:0]      len_q;
  logic [5:0]       rnd_q;
  logic [1:0]       cnt_q;
  logic             last_blk_q;   // compression in progress is the final one
  logic             extra_q;      // one more block (padding and length) must follow
  logic [WordW-1:0] out_q;
  logic [2:0]       oidx_q;

  logic             take;
  logic [WordW-1:0] in_word, pad_w, s0, s1, wnew, t1, t2;
  logic [WordW-1:0] e, a, big0, big1, ch, mj;
  logic [2:0]       cnt_in;
  logic [2:0]       cnt_eff;
  logic [63:0]      len_new;
  logic [4:0]       fin_fill;
  logic             fin_full;
  logic             fin_carry;

  assign in_word = s_axis_tdata[31:0];
  assign cnt_in  = s_axis_tdata[34:32];
  assign cnt_eff = (!s_axis_tlast || cnt_in > 3'd4) ? 3'd4 : cnt_in;
  assign len_new = len_q + {61'd0, cnt_eff};
  assign take    = s_axis_tvalid && s_axis_tready;

  // Fill after a final word; a full word on a final takes two entries.
  assign fin_fill  = {1'b0, fill_q} + ((cnt_eff == 3'd4) ? 5'd2 : 5'd1);
  assign fin_full  = fin_fill[4];
  assign fin_carry = (fin_fill == 5'd17);

  always_comb begin
    case (cnt_eff)
      3'd0: pad_w = PadWord;
      3'd1: pad_w = {in_word[31:24], 24'h800000};
      3'd2: pad_w = {in_word[31:16], 16'h8000};
      3'd3: pad_w = {in_word[31:8], 8'h80};
      default: pad_w = in_word;
    endcase
  end

  // Round logic: w_q[0] is the schedule word of this round.
  assign s0   = {w_q[1][6:0], w_q[1][31:7]} ^ {w_q[1][17:0], w_q[1][31:18]} ^
                (w_q[1] >> 3);
  assign s1   = {w_q[14][16:0], w_q[14][31:17]} ^ {w_q[14][18:0], w_q[14][31:19]} ^
                (w_q[14] >> 10);
  assign wnew = w_q[0] + w_q[9] + s0 + s1;
  assign e    = v_q[4];
  assign a    = v_q[0];
  assign big1 = {e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]};
  assign ch   = (e & v_q[5]) ^ (~e & v_q[6]);
  assign t1   = v_q[7] + big1 + ch + round_k(rnd_q) + w_q[0];
  assign big0 = {a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]};
  assign mj   = (a & v_q[1]) ^ (a & v_q[2]) ^ (v_q[1] & v_q[2]);
  assign t2   = big0 + mj;

  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = (state_q == StEmit);
  assign m_axis_tdata  = {5'd0, oidx_q, out_q};
  assign m_axis_tlast  = (oidx_q == 3'd7);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (take) begin
          if (s_axis_tlast && !fin_full) state_d = StPad;
          else if (s_axis_tlast || fill_q == 4'd15) state_d = StLoad;
        end
      end
      StLoad:   state_d = StRound;
      StRound:  if (rnd_q == 6'(Rounds - 1)) state_d = StFinish;
      StFinish: begin
        if (last_blk_q) state_d = StEmit;
        else if (extra_q) state_d = StPad;
        else state_d = StIdle;
      end
      StPad: if (fill_q == 4'd15) state_d = StLoad;
      StEmit: if (m_axis_tready && oidx_q == 3'd7) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // Message window shifts toward index 0; writes enter at the fill position.
  always_ff @(posedge clk_i) begin
    if (state_q == StRound) begin
      for (int i = 0; i < BlockLen - 1; i++) w_q[i] <= w_q[i+1];
      w_q[BlockLen-1] <= wnew;
    end else if (state_q == StIdle && take) begin
      if (s_axis_tlast && cnt_eff != 3'd4) w_q[fill_q] <= pad_w;
      else w_q[fill_q] <= in_word;
      if (s_axis_tlast && cnt_eff == 3'd4 && fill_q != 4'd15)
        w_q[fill_q + 4'd1] <= PadWord;
    end else if (state_q == StPad) begin
      if (fill_q == 4'd14 && !cnt_q[0]) w_q[fill_q] <= len_q[60:29];
      else if (fill_q == 4'd15 && !cnt_q[0]) w_q[fill_q] <= {len_q[28:0], 3'b000};
      else if (cnt_q[1] && fill_q == 4'd0) w_q[fill_q] <= PadWord;
      else w_q[fill_q] <= '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q     <= '0;
      len_q      <= '0;
      rnd_q      <= '0;
      cnt_q      <= '0;
      last_blk_q <= 1'b0;
      extra_q    <= 1'b0;
      oidx_q     <= '0;
      for (int i = 0; i < 8; i++) cv_q[i] <= hash_init(3'(i));
    end else begin
      case (state_q)
        StIdle: begin
          if (take) begin
            len_q <= len_new;
            if (!s_axis_tlast) begin
              fill_q <= fill_q + 4'd1;
            end else begin
              // cnt_q[0]: length words go into a following block.
              // cnt_q[1]: the pad word goes at index 0 of the following block.
              if (fin_full) begin
                // The final word completes the block, which is compressed first.
                fill_q  <= 4'd0;
                cnt_q   <= {fin_carry, 1'b1};
                extra_q <= 1'b1;
              end else begin
                fill_q  <= fin_fill[3:0];
                cnt_q   <= {1'b0, fin_fill[3:0] == 4'd15};
                extra_q <= (fin_fill[3:0] == 4'd15);
              end
              last_blk_q <= 1'b0;
            end
          end
        end
        StPad: begin
          fill_q <= fill_q + 4'd1;
          if (fill_q == 4'd15 && !cnt_q[0]) last_blk_q <= 1'b1;
        end
        StLoad: begin
          rnd_q <= '0;
          for (int i = 0; i < 8; i++) v_q[i] <= cv_q[i];
        end
        StRound: begin
          v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= e; v_q[4] <= v_q[3] + t1;
          v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= a; v_q[0] <= t1 + t2;
          rnd_q <= rnd_q + 6'd1;
        end
        StFinish: begin
          for (int i = 0; i < 8; i++) cv_q[i] <= cv_q[i] + v_q[i];
          if (extra_q && !last_blk_q) begin
            extra_q <= 1'b0;
            cnt_q   <= {cnt_q[1], 1'b0};
          end
          if (last_blk_q) begin
            out_q  <= cv_q[0] + v_q[0];
            oidx_q <= '0;
          end
        end
        StEmit: begin
          if (m_axis_tready) begin
            oidx_q <= oidx_q + 3'd1;
            out_q  <= cv_q[oidx_q + 3'd1];
            if (oidx_q == 3'd7) begin
              for (int i = 0; i < 8; i++) cv_q[i] <= hash_init(3'(i));
              len_q      <= '0;
              fill_q     <= '0;
              last_blk_q <= 1'b0;
              cnt_q      <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // A full block goes to StLoad directly; the pad path reaches it
  // via StPad when the last index has been written.
endmodule
`default_nettype wire

>>> tb/sv/sha256_message_hasher_tb.sv
`timescale 1ns / 100ps

class sha_scoreboard;
  logic [31:0] chain [8];
  logic [31:0] blk [16];
  int unsigned fill;
  logic [63:0] byte_len;
  logic [35:0] digest_q [$];  // {last, index, word}
  int unsigned errors;
  int unsigned digests;

  function new();
    errors = 0;
    digests = 0;
    restart();
    fill = 0;
  endfunction

  function void restart();
    chain[0] = 32'h6a09e667; chain[1] = 32'hbb67ae85;
    chain[2] = 32'h3c6ef372; chain[3] = 32'ha54ff53a;
    chain[4] = 32'h510e527f; chain[5] = 32'h9b05688c;
    chain[6] = 32'h1f83d9ab; chain[7] = 32'h5be0cd19;
    byte_len = '0;
  endfunction

  function logic [31:0] rotr(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function logic [31:0] kconst(int i);
    logic [31:0] k [64];
    k = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };
    return k[i];
  endfunction

  function void compress();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] s0, s1, t1, t2;
    for (int i = 0; i < 16; i++) w[i] = blk[i];
    for (int i = 16; i < 64; i++) begin
      s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = w[i-16] + w[i-7] + s0 + s1;
    end
    for (int i = 0; i < 8; i++) v[i] = chain[i];
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + kconst(i) + w[i];
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain[i] += v[i];
  endfunction

  function void append(logic [31:0] w);
    blk[fill] = w;
    fill = (fill + 1) % 16;
    if (fill == 0) compress();
  endfunction

  function void note_word(logic [31:0] data, logic [2:0] cnt, logic fin);
    int unsigned n;
    logic [31:0] keep;
    logic [63:0] bits;
    n = (cnt > 4 || !fin) ? 4 : cnt;
    byte_len += n;
    if (!fin) begin
      append(data);
      return;
    end
    if (n == 4) begin
      append(data);
      append(32'h8000_0000);
    end else begin
      keep = (n == 0) ? 32'h0 : (32'hffff_ffff << (32 - 8 * n));
      append((data & keep) | (32'h80 << (24 - 8 * n)));
    end
    if (fill > 14) begin
      while (fill < 16) blk[fill++] = '0;
      fill = 0;
      compress();
    end
    while (fill < 14) blk[fill++] = '0;
    bits = byte_len << 3;
    blk[14] = bits[63:32];
    blk[15] = bits[31:0];
    fill = 0;
    compress();
    for (int i = 0; i < 8; i++) digest_q.push_back({(i == 7), 3'(i), chain[i]});
    restart();
  endfunction

  function void check_digest(logic [31:0] data, logic [2:0] idx, logic lst);
    logic [35:0] exp_w;
    if (digest_q.size() == 0) begin
      $display("%0t: unexpected digest word: expected none, actual %h idx %0d last %0b",
               $time, data, idx, lst);
      errors++;
      return;
    end
    exp_w = digest_q.pop_front();
    if (exp_w[31:0] !== data) begin
      $display("%0t: digest word mismatch: expected %h, actual %h", $time, exp_w[31:0], data);
      errors++;
    end
    if (exp_w[34:32] !== idx) begin
      $display("%0t: word index mismatch: expected %0d, actual %0d", $time, exp_w[34:32], idx);
      errors++;
    end
    if (exp_w[35] !== lst) begin
      $display("%0t: digest last mismatch: expected %0b, actual %0b", $time, exp_w[35], lst);
      errors++;
    end
    if (lst === 1'b1) digests++;
  endfunction

  function int unsigned pending();
    return digest_q.size();
  endfunction
endclass

module sha256_message_hasher_tb;
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;   // message_word, byte_count
  logic        s_axis_tlast = 1'b0; // message_end
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;        // digest_word, word_index
  logic        m_axis_tlast;        // digest_last

  sha_scoreboard sb = new();
  int unsigned words_sent = 0;
  int unsigned messages_sent = 0;
  bit hold_done = 0;

  sha256_message_hasher u_top (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic send_word(logic [31:0] data, logic [2:0] cnt, logic fin);
    int gap;
    gap = $urandom_range(0, 3);
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'b0, cnt, data};
    s_axis_tlast  <= fin;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_word(data, cnt, fin);
    words_sent++;
  endtask

  // Body words carry a random byte count, which the block ignores.
  task automatic send_message(int body, logic [2:0] cnt);
    for (int i = 0; i < body; i++) send_word($urandom, 3'($urandom_range(0, 7)), 1'b0);
    send_word($urandom, cnt, 1'b1);
    messages_sent++;
  endtask

  // The last word must not stay offered while the sender waits.
  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Receiver with random stalls and one long hold-off so the block backs up.
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      if (!hold_done && sb.digests == 4) begin
        hold_done = 1;
        repeat (400) begin
          @(negedge clk_i);
          m_axis_tready <= 1'b0;
        end
      end
      gap = $urandom_range(0, 3);
      repeat (gap) begin
        @(negedge clk_i);
        m_axis_tready <= 1'b0;
      end
      @(negedge clk_i);
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      sb.check_digest(m_axis_tdata[31:0], m_axis_tdata[34:32], m_axis_tlast);
    end
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int cnt_sel;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty message, full and short final words, counts above four,
    // all-ones and all-zeros data, and lengths around the extra-block boundary.
    send_word(32'h0, 3'd0, 1'b1);
    send_word(32'hffff_ffff, 3'd4, 1'b1);
    send_word(32'hffff_ffff, 3'd1, 1'b1);
    send_word(32'hffff_ffff, 3'd2, 1'b1);
    send_word(32'hffff_ffff, 3'd3, 1'b1);
    send_word(32'h0, 3'd7, 1'b1);
    send_word(32'h1234_5678, 3'd1, 1'b0);
    send_word(32'h0, 3'd5, 1'b1);
    send_message(12, 3'd4);
    send_message(13, 3'd4);
    send_message(13, 3'd3);
    send_message(14, 3'd0);
    messages_sent += 7;

    wait_drained();
    send_message(15, 3'd2);
    // Sender pause: nothing goes in until every digest has come back.
    wait_drained();
    repeat (100) @(negedge clk_i);

    while (words_sent < 360) begin
      cnt_sel = $urandom_range(0, 9);
      if ($urandom_range(0, 9) == 0)
        send_message($urandom_range(17, 40), 3'($urandom_range(0, 7)));
      else
        send_message($urandom_range(0, 16), (cnt_sel < 8) ? 3'(cnt_sel % 5)
                                                          : 3'($urandom_range(5, 7)));
    end

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    wait_drained();
    repeat (200) @(posedge clk_i);
    $display("Hashed %0d messages from %0d words, %0d digests checked.",
             messages_sent, words_sent, sb.digests);
    $display("Covered empty, short and padded finals with random stalls on both sides.");
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
